@@ hdl/virtual_interrupt_priority_picker_assert.svh @@
// Assertion macros used by the interrupt priority picker back end.
`ifndef VIRTUAL_INTERRUPT_PRIORITY_PICKER_ASSERT_SVH
`define VIRTUAL_INTERRUPT_PRIORITY_PICKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VIPP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VIPP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/vipp_pkg.sv @@
// Shared types, constants and helpers for the interrupt priority picker.
package vipp_pkg;

    // Bank geometry
    localparam int FLAG_WORDS  = 7;
    localparam int PRIO_WORDS  = FLAG_WORDS * 8;
    localparam int LEVEL_BITS  = 3;
    localparam int FLAG_IDX_W  = (FLAG_WORDS > 1) ? $clog2(FLAG_WORDS) : 1;
    localparam int PRIO_IDX_W  = $clog2(PRIO_WORDS);

    // Stream widths
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 48;
    localparam int CFG_W       = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Transaction kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_PICK  = 2'd2;

    // Register banks
    localparam logic [1:0] BANK_FLAG   = 2'd0;
    localparam logic [1:0] BANK_ENABLE = 2'd1;
    localparam logic [1:0] BANK_PRIO   = 2'd2;

    typedef enum logic [1:0] {
        ACC_PLAIN  = 2'd0,
        ACC_CLEAR  = 2'd1,
        ACC_SET    = 2'd2,
        ACC_INVERT = 2'd3
    } acc_t;

    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_ERR  = 2'd1,
        OP_REG  = 2'd2,
        OP_PICK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TGT_FLAG   = 2'd0,
        TGT_ENABLE = 2'd1,
        TGT_PRIO   = 2'd2
    } tgt_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t                   op;
        tgt_t                  tgt;
        logic                  wr;
        acc_t                  acc;
        logic [5:0]            idx;
        logic [31:0]           data;
        logic [LEVEL_BITS-1:0] gl;
        logic                  tp;
    } cmd_t;

    // One result item, read_data in the low bits
    typedef struct packed {
        logic [LEVEL_BITS-1:0] irq_level;
        logic [7:0]            irq_number;
        logic                  found;
        logic                  access_error;
        logic [31:0]           read_data;
    } result_t;

    // Apply a write mode to an old word
    function automatic logic [31:0] apply_write(input logic [31:0] old_word,
                                                input logic [31:0] wdata,
                                                input acc_t        acc);
        logic [31:0] word;
        case (acc)
            ACC_PLAIN:  word = wdata;
            ACC_CLEAR:  word = old_word & ~wdata;
            ACC_SET:    word = old_word | wdata;
            ACC_INVERT: word = old_word ^ wdata;
            default:    word = wdata;
        endcase
        return word;
    endfunction

endpackage

@@ hdl/virtual_interrupt_priority_picker.sv @@
// Top level of the virtual interrupt controller with priority picker.
//
// Input stream s_axis: one transaction is a register read, a register write
// (plain, clear, set, invert) or a pick of the highest pending interrupt.
// Output stream m_axis: exactly one result transaction per input transaction,
// in order. cfg_valid/cfg_data write the timer interrupt number; cfg_ready is
// always high; the user must make writes while the block is idle (not enforced).
// The front end classifies each transaction into a two-entry command queue;
// the back end executes one command at a time.
// Steps by kind: an error or unused kind goes straight to the result; a
// flag/enable access reads and may write its word; a priority word access reads
// the word, then writes it back; a pick may first set the timer flag, then scans
// the 56-word priority memory, one word per cycle through its single read port.
// Reset clears the flag and enable banks, the timer number, the queue and the
// result valid; priority words read as zero until written.
// When m_axis_tready is low the result is held; the back end holds its next
// result, and the queue fills before s_axis_tready drops.
module virtual_interrupt_priority_picker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vipp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // bank[1:0], word_index[7:2], access_type[9:8], write_data[41:10],
    // guest_level[44:42], timer_pending[45], zero[47:46]
    input  logic [vipp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [vipp_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_data[31:0], access_error[32], found[33], irq_number[41:34],
    // irq_level[44:42], zero[47:45]
    output logic [vipp_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import vipp_pkg::*;

    logic    push_valid, push_ready;
    cmd_t    push_cmd;
    logic    pop_valid, pop_ready;
    cmd_t    pop_cmd;
    result_t res;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = M_TDATA_W'(res);

    // Accept and classify
    vipp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    // Decouple front and back
    vipp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Execute and deliver results
    vipp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

endmodule

@@ hdl/vipp_front.sv @@
// Front end: accepts input transactions and classifies them into commands.
module vipp_front (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // bank[1:0], word_index[7:2], access_type[9:8], write_data[41:10],
    // guest_level[44:42], timer_pending[45], zero[47:46]
    input  logic [vipp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [vipp_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           push_valid,
    input  logic                           push_ready,
    output vipp_pkg::cmd_t                 push_cmd
);
    import vipp_pkg::*;

    logic [1:0] bank;
    logic [5:0] word_index;
    logic       idx_ok;

    assign bank       = s_axis_tdata[1:0];
    assign word_index = s_axis_tdata[7:2];

    // Pass the handshake straight to the queue
    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

    // Check the word index against the selected bank
    always_comb
    begin
        case (bank)
            BANK_FLAG:   idx_ok = (32'(word_index) < FLAG_WORDS);
            BANK_ENABLE: idx_ok = (32'(word_index) < FLAG_WORDS);
            BANK_PRIO:   idx_ok = (32'(word_index) < PRIO_WORDS);
            default:     idx_ok = 1'b0;
        endcase
    end

    // Classify the transaction
    always_comb
    begin
        push_cmd.idx  = word_index;
        push_cmd.acc  = acc_t'(s_axis_tdata[9:8]);
        push_cmd.data = s_axis_tdata[41:10];
        push_cmd.gl   = s_axis_tdata[44:42];
        push_cmd.tp   = s_axis_tdata[45];
        push_cmd.wr   = (s_axis_tuser == KIND_WRITE);
        case (bank)
            BANK_FLAG:   push_cmd.tgt = TGT_FLAG;
            BANK_ENABLE: push_cmd.tgt = TGT_ENABLE;
            default:     push_cmd.tgt = TGT_PRIO;
        endcase
        case (s_axis_tuser)
            KIND_READ,
            KIND_WRITE: push_cmd.op = idx_ok ? OP_REG : OP_ERR;
            KIND_PICK:  push_cmd.op = OP_PICK;
            default:    push_cmd.op = OP_NOP;
        endcase
    end

endmodule

@@ hdl/vipp_queue.sv @@
// Short command queue between the front end and the execution back end.
module vipp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  vipp_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output vipp_pkg::cmd_t pop_cmd
);
    import vipp_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/vipp_back.sv @@
// Back end: register banks, priority memory, pick scanner and result register.
`include "virtual_interrupt_priority_picker_assert.svh"

module vipp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [vipp_pkg::CFG_W-1:0] cfg_data,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  vipp_pkg::cmd_t             cmd,
    output logic                       res_valid,
    input  logic                       res_ready,
    output vipp_pkg::result_t          res
);
    import vipp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_REG     = 7'b0000010,
        ST_PRIO_RD = 7'b0000100,
        ST_PRIO_WB = 7'b0001000,
        ST_TIMER   = 7'b0010000,
        ST_SCAN    = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg;
    logic [CFG_W-1:0]        timer_reg;

    logic [31:0]             flag_reg [FLAG_WORDS];
    logic [31:0]             en_reg   [FLAG_WORDS];
    logic [31:0]             prio_mem [PRIO_WORDS];
    logic [PRIO_WORDS-1:0]   prio_vld_reg;
    logic [31:0]             prio_q_reg;
    logic                    prio_vq_reg;

    logic [FLAG_IDX_W-1:0]   wsel_reg, wsel_next;
    logic [2:0]              jsel_reg, jsel_next;
    logic                    run_reg, run_next;
    logic                    ev_valid_reg, ev_valid_next;
    logic [FLAG_IDX_W-1:0]   ev_w_reg;
    logic [2:0]              ev_j_reg;
    logic [LEVEL_BITS-1:0]   best_reg, best_next;
    logic                    found_reg, found_next;
    logic [7:0]              num_reg, num_next;

    result_t                 pend_reg, pend_next;
    result_t                 res_reg;
    logic                    res_valid_reg, res_valid_next;

    logic [FLAG_IDX_W-1:0]   fe_idx;
    logic [31:0]             flag_word, en_word;
    logic [31:0]             prio_word;
    logic [PRIO_IDX_W-1:0]   prio_addr;
    logic                    prio_we;
    logic [31:0]             old_word, new_word;
    logic                    timer_ok;
    logic                    flag_we, en_we;
    logic [FLAG_IDX_W-1:0]   fe_wa;
    logic [31:0]             flag_wd;
    logic [LEVEL_BITS-1:0]   best_c;
    logic                    found_c;
    logic [7:0]              num_c;
    logic                    out_free;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || res_ready;
    assign timer_ok  = (32'(timer_reg[7:5]) < FLAG_WORDS);

    // Select the one flag/enable word read this cycle
    always_comb
    begin
        case (state_reg)
            ST_SCAN:  fe_idx = ev_w_reg;
            ST_TIMER: fe_idx = FLAG_IDX_W'(timer_reg[7:5]);
            default:  fe_idx = cmd_reg.idx[FLAG_IDX_W-1:0];
        endcase
    end

    assign flag_word = flag_reg[fe_idx];
    assign en_word   = en_reg[fe_idx];
    assign prio_word = prio_vq_reg ? prio_q_reg : '0;

    // Register access data path
    always_comb
    begin
        case (state_reg)
            ST_PRIO_WB: old_word = prio_word;
            default:    old_word = (cmd_reg.tgt == TGT_FLAG) ? flag_word : en_word;
        endcase
        new_word = apply_write(old_word, cmd_reg.data, cmd_reg.acc);
    end

    // Priority memory address: scan position or accessed word
    assign prio_addr = (state_reg == ST_SCAN) ? PRIO_IDX_W'({wsel_reg, jsel_reg})
                                              : cmd_reg.idx[PRIO_IDX_W-1:0];
    assign prio_we   = (state_reg == ST_PRIO_WB) && cmd_reg.wr;

    // Flag and enable write port
    always_comb
    begin
        flag_we = 1'b0;
        en_we   = 1'b0;
        fe_wa   = fe_idx;
        flag_wd = new_word;
        if (state_reg == ST_REG && cmd_reg.wr)
        begin
            flag_we = (cmd_reg.tgt == TGT_FLAG);
            en_we   = (cmd_reg.tgt == TGT_ENABLE);
        end
        else if (state_reg == ST_TIMER && cmd_reg.tp && timer_ok)
        begin
            flag_we = 1'b1;
            flag_wd = flag_word | (32'd1 << timer_reg[4:0]);
        end
    end

    // Evaluate four interrupts of one priority word, highest bit first
    always_comb
    begin
        best_c  = best_reg;
        found_c = found_reg;
        num_c   = num_reg;
        for (int k = 3; k >= 0; k--)
        begin
            if (flag_word[{ev_j_reg, 2'(k)}] && en_word[{ev_j_reg, 2'(k)}]
                && (prio_word[k*8+2 +: LEVEL_BITS] > best_c))
            begin
                best_c  = prio_word[k*8+2 +: LEVEL_BITS];
                found_c = 1'b1;
                num_c   = 8'({PRIO_IDX_W'({ev_w_reg, ev_j_reg}), 2'(k)});
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        wsel_next      = wsel_reg;
        jsel_next      = jsel_reg;
        run_next       = run_reg;
        ev_valid_next  = 1'b0;
        best_next      = best_reg;
        found_next     = found_reg;
        num_next       = num_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg && !res_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pend_next = '0;
                    case (cmd.op)
                        OP_ERR:
                        begin
                            pend_next.access_error = 1'b1;
                            state_next = ST_DONE;
                        end
                        OP_REG:  state_next = (cmd.tgt == TGT_PRIO) ? ST_PRIO_RD : ST_REG;
                        OP_PICK: state_next = ST_TIMER;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_REG:
            begin
                pend_next.read_data = cmd_reg.wr ? new_word : old_word;
                state_next = ST_DONE;
            end
            ST_PRIO_RD:
            begin
                state_next = ST_PRIO_WB;
            end
            ST_PRIO_WB:
            begin
                pend_next.read_data = cmd_reg.wr ? new_word : old_word;
                state_next = ST_DONE;
            end
            ST_TIMER:
            begin
                wsel_next  = '0;
                jsel_next  = 3'd7;
                run_next   = 1'b1;
                best_next  = cmd_reg.gl;
                found_next = 1'b0;
                num_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Issue reads: word 0 upward, byte group 7 downward
                if (run_reg)
                begin
                    ev_valid_next = 1'b1;
                    if (jsel_reg == 3'd0)
                    begin
                        jsel_next = 3'd7;
                        if (wsel_reg == FLAG_IDX_W'(FLAG_WORDS - 1))
                        begin
                            run_next = 1'b0;
                        end
                        else
                        begin
                            wsel_next = wsel_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        jsel_next = jsel_reg - 1'b1;
                    end
                end
                if (ev_valid_reg)
                begin
                    best_next  = best_c;
                    found_next = found_c;
                    num_next   = num_c;
                end
                if (!run_reg && !ev_valid_reg)
                begin
                    pend_next.found      = found_reg;
                    pend_next.irq_number = found_reg ? num_reg : '0;
                    pend_next.irq_level  = found_reg ? best_reg : '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 1'b0;
            ev_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            timer_reg     <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            ev_valid_reg  <= ev_valid_next;
            res_valid_reg <= res_valid_next;
            found_reg     <= found_next;
            if (cfg_valid)
            begin
                timer_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wsel_reg <= wsel_next;
        jsel_reg <= jsel_next;
        ev_w_reg <= wsel_reg;
        ev_j_reg <= jsel_reg;
        best_reg <= best_next;
        num_reg  <= num_next;
        pend_reg <= pend_next;
        if (cmd_ready && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            res_reg <= pend_reg;
        end
    end

    // Flag and enable banks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FLAG_WORDS; i++)
            begin
                flag_reg[i] <= '0;
                en_reg[i]   <= '0;
            end
        end
        else
        begin
            if (flag_we)
            begin
                flag_reg[fe_wa] <= flag_wd;
            end
            if (en_we)
            begin
                en_reg[fe_wa] <= new_word;
            end
        end
    end

    // Priority memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (prio_we)
        begin
            prio_mem[prio_addr] <= new_word;
        end
        prio_q_reg <= prio_mem[prio_addr];
    end

    // Mark written priority words; unwritten words read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_vld_reg <= '0;
            prio_vq_reg  <= 1'b0;
        end
        else
        begin
            if (prio_we)
            begin
                prio_vld_reg[prio_addr] <= 1'b1;
            end
            prio_vq_reg <= prio_vld_reg[prio_addr];
        end
    end

    `VIPP_ASSERT_IMP(a_eval_only_in_scan, ev_valid_reg, state_reg == ST_SCAN, "evaluation outside scan")
    `VIPP_ASSERT_IMP(a_found_above_guest, found_reg && state_reg == ST_SCAN, best_reg > cmd_reg.gl, "picked level not above guest level")
    `VIPP_ASSERT_NEXT(a_pop_starts_work, cmd_valid && cmd_ready, state_reg != ST_IDLE, "command taken but sequencer idle")

endmodule

@@ tb/virtual_interrupt_priority_picker_checker.sv @@
// Checker for the interrupt priority picker: predicts each result and compares it.
module virtual_interrupt_priority_picker_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [vipp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // bank[1:0], word_index[7:2], access_type[9:8], write_data[41:10],
    // guest_level[44:42], timer_pending[45], zero[47:46]
    input  logic [vipp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [vipp_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_data[31:0], access_error[32], found[33], irq_number[41:34],
    // irq_level[44:42], zero[47:45]
    input  logic [vipp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                             fail_count,
    output int                             outstanding
);
    import vipp_pkg::*;

    typedef struct packed {
        logic [2:0]            pad;
        logic [LEVEL_BITS-1:0] irq_level;
        logic [7:0]            irq_number;
        logic                  found;
        logic                  access_error;
        logic [31:0]           read_data;
    } irq_reply_t;

    // Shadow copy of the register banks and the timer number
    logic [31:0]      flag_mem   [FLAG_WORDS];
    logic [31:0]      enable_mem [FLAG_WORDS];
    logic [31:0]      prio_mem   [PRIO_WORDS];
    logic [CFG_W-1:0] timer_num;

    irq_reply_t replies_due [$];
    irq_reply_t got_reply;
    irq_reply_t want_reply;
    int         k;

    initial fail_count = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Execute one transaction on the shadow banks and return its reply
    function automatic irq_reply_t service_request(input logic [1:0]  kind,
                                                   input logic [1:0]  bank,
                                                   input logic [5:0]  idx,
                                                   input acc_t        acc,
                                                   input logic [31:0] wdata,
                                                   input logic [2:0]  gl,
                                                   input logic        tp);
        irq_reply_t r;
        logic [31:0] word;
        logic        in_bank;
        logic [2:0]  best;
        logic [2:0]  lvl;
        int          w;
        int          b;
        int          irq;
        int          tw;
        r = '0;
        if (kind == KIND_READ || kind == KIND_WRITE) begin
            if (bank == BANK_FLAG || bank == BANK_ENABLE)
                in_bank = (idx < FLAG_WORDS);
            else if (bank == BANK_PRIO)
                in_bank = (idx < PRIO_WORDS);
            else
                in_bank = 1'b0;
            if (!in_bank) begin
                r.access_error = 1'b1;
            end
            else begin
                case (bank)
                    BANK_FLAG:   word = flag_mem[idx];
                    BANK_ENABLE: word = enable_mem[idx];
                    default:     word = prio_mem[idx];
                endcase
                if (kind == KIND_WRITE) begin
                    case (acc)
                        ACC_PLAIN: word = wdata;
                        ACC_CLEAR: word = word & ~wdata;
                        ACC_SET:   word = word | wdata;
                        default:   word = word ^ wdata;
                    endcase
                    case (bank)
                        BANK_FLAG:   flag_mem[idx] = word;
                        BANK_ENABLE: enable_mem[idx] = word;
                        default:     prio_mem[idx] = word;
                    endcase
                end
                r.read_data = word;
            end
        end
        else if (kind == KIND_PICK) begin
            // Raise the timer flag first if pending, unless its number lies past the flag bank
            tw = int'(timer_num >> 5);
            if (tp && tw < FLAG_WORDS)
                flag_mem[tw][timer_num[4:0]] = 1'b1;
            // Scan words upward, bits downward; only a strictly higher level wins
            best = gl;
            for (w = 0; w < FLAG_WORDS; w++) begin
                for (b = 31; b >= 0; b--) begin
                    if (flag_mem[w][b] && enable_mem[w][b]) begin
                        irq = w * 32 + b;
                        lvl = prio_mem[irq >> 2][(irq & 3) * 8 + 2 +: 3];
                        if (lvl > best) begin
                            best = lvl;
                            r.found = 1'b1;
                            r.irq_number = irq[7:0];
                            r.irq_level = lvl;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // Watch the three channels; predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (k = 0; k < FLAG_WORDS; k++) begin
                flag_mem[k] = '0;
                enable_mem[k] = '0;
            end
            for (k = 0; k < PRIO_WORDS; k++)
                prio_mem[k] = '0;
            timer_num = '0;
            replies_due.delete();
            outstanding = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                timer_num = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(service_request(s_axis_tuser[1:0], s_axis_tdata[1:0],
                    s_axis_tdata[7:2], acc_t'(s_axis_tdata[9:8]), s_axis_tdata[41:10],
                    s_axis_tdata[44:42], s_axis_tdata[45]));
            if (m_axis_tvalid && m_axis_tready) begin
                got_reply = m_axis_tdata;
                if (replies_due.size() == 0) begin
                    report("unexpected result", 64'(m_axis_tdata), 64'd0);
                end
                else begin
                    want_reply = replies_due.pop_front();
                    if (got_reply.read_data !== want_reply.read_data)
                        report("read_data", 64'(got_reply.read_data),
                               64'(want_reply.read_data));
                    if (got_reply.access_error !== want_reply.access_error)
                        report("access_error", 64'(got_reply.access_error),
                               64'(want_reply.access_error));
                    if (got_reply.found !== want_reply.found)
                        report("found", 64'(got_reply.found), 64'(want_reply.found));
                    if (got_reply.irq_number !== want_reply.irq_number)
                        report("irq_number", 64'(got_reply.irq_number),
                               64'(want_reply.irq_number));
                    if (got_reply.irq_level !== want_reply.irq_level)
                        report("irq_level", 64'(got_reply.irq_level),
                               64'(want_reply.irq_level));
                    if (got_reply.pad !== want_reply.pad)
                        report("padding", 64'(got_reply.pad), 64'(want_reply.pad));
                end
            end
            outstanding = replies_due.size();
        end
    end

endmodule

@@ tb/tb_virtual_interrupt_priority_picker.sv @@
// Testbench top for the interrupt priority picker: stimulus, stalls and verdict.
module tb_virtual_interrupt_priority_picker;
    import vipp_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] BANK_UNUSED = 2'd3;
    localparam int         ITEM_TARGET = 1600;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         DRAIN_WAIT  = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int stall_left  = 0;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;

    virtual_interrupt_priority_picker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    virtual_interrupt_priority_picker_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Clock: period 8
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** virtual_interrupt_priority_picker: FAILED **");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int draw_idle(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [5:0] draw_valid_index(input logic [1:0] bank);
        if (bank == BANK_PRIO)
            return 6'($urandom_range(0, PRIO_WORDS - 1));
        return 6'($urandom_range(0, FLAG_WORDS - 1));
    endfunction

    // Write data: random, single bit, extremes, sparse, single hole
    function automatic logic [31:0] draw_write_data();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'd1 << $urandom_range(0, 31);
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom & $urandom & $urandom;
            default: return ~(32'd1 << $urandom_range(0, 31));
        endcase
    endfunction

    // Result side: stall at random
    always @(negedge clk)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else begin
            m_axis_tready <= 1'b1;
            stall_left <= draw_idle(rx_calm);
        end
    end

    // Send one transaction after a random gap; valid stays high on return
    task automatic send_item(input logic [1:0]  kind,
                             input logic [1:0]  bank,
                             input logic [5:0]  idx,
                             input acc_t        acc,
                             input logic [31:0] wdata,
                             input logic [2:0]  gl,
                             input logic        tp);
        int gap;
        gap = draw_idle(tx_calm);
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {2'b00, tp, gl, wdata, acc, idx, bank};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drop valid and hold until every result has come back
    task automatic await_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_timer(input logic [CFG_W-1:0] value);
        await_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [1:0]  kind;
        logic [1:0]  bank;
        logic [5:0]  idx;
        acc_t        acc;
        logic [31:0] wdata;
        logic [2:0]  gl;
        logic        tp;
        int          roll;
        int          useful;
        int          scene;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every write mode, equal-level tie, guest level extremes
        send_item(KIND_READ,  BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_FLAG,   6'd0,  ACC_PLAIN,  32'hFFFF_FFFF, 3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_FLAG,   6'd0,  ACC_CLEAR,  32'h0000_FFFF, 3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_FLAG,   6'd0,  ACC_SET,    32'h0000_00F0, 3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_FLAG,   6'd0,  ACC_INVERT, 32'hFFFF_FFFF, 3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_ENABLE, 6'd0,  ACC_PLAIN,  32'hFFFF_FFFF, 3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_PRIO,   6'd7,  ACC_PLAIN,  32'h0C0C_0C0C, 3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_FLAG,   6'd0,  ACC_PLAIN,  32'hC000_0001, 3'd0, 1'b0);
        send_item(KIND_PICK,  BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd0, 1'b0);
        send_item(KIND_PICK,  BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd3, 1'b0);
        send_item(KIND_WRITE, BANK_PRIO,   6'd0,  ACC_PLAIN,  32'h0000_001C, 3'd0, 1'b0);
        send_item(KIND_PICK,  BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd3, 1'b0);
        send_item(KIND_PICK,  BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd7, 1'b1);
        send_item(KIND_WRITE, BANK_ENABLE, 6'd6,  ACC_PLAIN,  32'hFFFF_FFFF, 3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_PRIO,   6'd55, ACC_PLAIN,  32'hFFFF_FFFF, 3'd0, 1'b0);
        send_item(KIND_READ,  BANK_FLAG,   6'd7,  ACC_PLAIN,  32'h0,         3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_ENABLE, 6'd63, ACC_INVERT, 32'hFFFF_FFFF, 3'd7, 1'b1);
        send_item(KIND_READ,  BANK_PRIO,   6'd56, ACC_PLAIN,  32'h0,         3'd0, 1'b0);
        send_item(KIND_WRITE, BANK_UNUSED, 6'd0,  ACC_PLAIN,  32'h1234_5678, 3'd0, 1'b0);
        send_item(KIND_UNUSED, BANK_UNUSED, 6'd63, ACC_INVERT, 32'hFFFF_FFFF, 3'd7, 1'b1);
        send_item(KIND_WRITE, BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd0, 1'b0);

        // Timer at the last interrupt, then past the flag bank
        write_timer(8'd223);
        send_item(KIND_PICK,  BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd6, 1'b1);
        send_item(KIND_READ,  BANK_FLAG,   6'd6,  ACC_PLAIN,  32'h0,         3'd0, 1'b0);
        write_timer(8'd224);
        send_item(KIND_PICK,  BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd0, 1'b1);
        write_timer(8'd255);
        send_item(KIND_PICK,  BANK_FLAG,   6'd0,  ACC_PLAIN,  32'h0,         3'd0, 1'b1);

        // Random scenes: mostly register setup and picks, some bad accesses
        useful = 0;
        scene = 0;
        while (useful < ITEM_TARGET) begin
            if (scene % 8 == 7) begin
                case ($urandom_range(0, 5))
                    0:       write_timer(8'd0);
                    1:       write_timer(8'd223);
                    2:       write_timer(8'd224);
                    3:       write_timer(8'd255);
                    4:       write_timer(8'($urandom_range(0, 255)));
                    default: write_timer(8'($urandom_range(0, 223)));
                endcase
            end
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 14)) begin
                kind  = KIND_PICK;
                bank  = 2'($urandom_range(0, 3));
                idx   = 6'($urandom_range(0, 63));
                acc   = acc_t'($urandom_range(0, 3));
                wdata = $urandom;
                gl    = 3'($urandom_range(0, 7));
                tp    = 1'($urandom_range(0, 1));
                roll  = $urandom_range(0, 99);
                if (roll < 80) begin
                    bank = 2'($urandom_range(0, 2));
                    idx  = draw_valid_index(bank);
                end
                if (roll < 45) begin
                    kind = KIND_PICK;
                end
                else if (roll < 80) begin
                    kind  = KIND_WRITE;
                    wdata = draw_write_data();
                end
                else if (roll < 90) begin
                    kind = KIND_READ;
                    bank = 2'($urandom_range(0, 2));
                    idx  = draw_valid_index(bank);
                end
                else if (roll < 97) begin
                    kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
                    if ($urandom_range(0, 1)) begin
                        bank = BANK_UNUSED;
                    end
                    else begin
                        bank = 2'($urandom_range(0, 2));
                        idx  = (bank == BANK_PRIO) ? 6'($urandom_range(PRIO_WORDS, 63))
                                                   : 6'($urandom_range(FLAG_WORDS, 63));
                    end
                end
                else begin
                    kind = KIND_UNUSED;
                end
                send_item(kind, bank, idx, acc, wdata, gl, tp);
                useful++;
            end
            scene++;
        end

        // Drain and settle
        await_idle();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("** virtual_interrupt_priority_picker: PASSED **");
        else
            $display("** virtual_interrupt_priority_picker: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/vipp_pkg.sv
hdl/vipp_front.sv
hdl/vipp_queue.sv
hdl/vipp_back.sv
hdl/virtual_interrupt_priority_picker.sv
tb/virtual_interrupt_priority_picker_checker.sv
tb/tb_virtual_interrupt_priority_picker.sv
